/* hdl/rrfp_pkg.sv */
// Shared types, codes and frame constants of the reader response frame parser.
package rrfp_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 2'd1;

	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;
	localparam logic [15:0] MAX_LENGTH_RST    = 16'd265;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_ACK  = 3'd1;
	localparam logic [2:0] PH_HEAD = 3'd2;
	localparam logic [2:0] PH_EXT  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_TAIL = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TIMEOUT  = 3'd1;
	localparam logic [2:0] ST_BAD_ACK  = 3'd2;
	localparam logic [2:0] ST_BAD_PRE  = 3'd3;
	localparam logic [2:0] ST_BAD_LCS  = 3'd4;
	localparam logic [2:0] ST_TOO_LONG = 3'd5;
	localparam logic [2:0] ST_BAD_TAIL = 3'd6;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	localparam logic [7:0] BYTE_FF = 8'hFF;
	localparam logic [7:0] BYTE_00 = 8'h00;

	localparam logic [15:0] TICK_MAX = 16'hFFFF;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [2:0]  status;
		logic        send_nack;
		logic [15:0] frame_length;
	} res_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [15:0] max_length;
	} cfg_t;

	// ACK frame 00 00 FF 00 FF 00
	function automatic logic [7:0] ack_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd2, 3'd4: b = BYTE_FF;
			default:    b = BYTE_00;
		endcase
		return b;
	endfunction

	// Preamble 00 00 FF
	function automatic logic [7:0] pre_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd2:    b = BYTE_FF;
			default: b = BYTE_00;
		endcase
		return b;
	endfunction

endpackage

/* hdl/rrfp_if.sv */
// Handshake channels of the parser: input beats, result beats, register writes.
interface rrfp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] rx_byte;
	modport source (output valid, output op, output rx_byte, input ready);
	modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface rrfp_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [2:0]  status;
	logic        send_nack;
	logic [15:0] frame_length;
	modport source (output valid, output kind, output payload_byte, output status,
		output send_nack, output frame_length, input ready);
	modport sink (input valid, input kind, input payload_byte, input status,
		input send_nack, input frame_length, output ready);
endinterface

interface rrfp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rrfp_pkg::CFG_IDX_W-1:0]   index;
	logic [15:0]                      data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/reader_response_frame_parser.sv */
// Top level of the reader response frame parser: registers, core and result register.
// Takes one beat (received byte, millisecond tick or start) per clock cycle; the result
// it causes, if any, is registered and shown on res in the cycle after the beat is
// accepted. The input stalls only while the result register holds a beat that res has
// not taken. Register writes are always accepted and act at once; payload is streamed
// before the DCS check, so discard it when the closing status is not ok.
module reader_response_frame_parser (
	input  logic         clk,
	input  logic         arst_n,
	rrfp_in_if.sink      rx,
	rrfp_out_if.source   res,
	rrfp_cfg_if.sink     cfg
);
	import rrfp_pkg::*;

	cfg_t cfg_q;
	logic accept;
	logic can_take;
	logic core_valid;
	res_t core_res;

	assign cfg.ready = 1'b1;
	assign rx.ready  = can_take;
	assign accept    = rx.valid && can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
			cfg_q.max_length    <= MAX_LENGTH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg.data;
				REG_MAX_LENGTH:    cfg_q.max_length    <= cfg.data;
				default: ;
			endcase
		end
	end

	rrfp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (rx.op),
		.rx_byte   (rx.rx_byte),
		.cfg       (cfg_q),
		.res_valid (core_valid),
		.res       (core_res)
	);

	rrfp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && core_valid),
		.res      (core_res),
		.can_take (can_take),
		.out      (res)
	);

endmodule

/* hdl/rrfp_core.sv */
// Frame state machine: one input beat per cycle while accept is high, next state and result in one pass.
module rrfp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         op,
	input  logic [7:0]         rx_byte,
	input  rrfp_pkg::cfg_t     cfg,
	output logic               res_valid,
	output rrfp_pkg::res_t     res
);
	import rrfp_pkg::*;

	logic [2:0]  phase_q,  phase_n;
	logic [15:0] pos_q,    pos_n;
	logic [15:0] len_q,    len_n;
	logic [7:0]  lhh_q,    lhh_n;
	logic [1:0]  flags_q,  flags_n;
	logic [7:0]  sum_q,    sum_n;
	logic [15:0] tick_q,   tick_n;

	logic [15:0] tick_inc;
	logic [16:0] pos_inc;
	logic [7:0]  sum_b;
	logic        to_nack;

	assign tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 16'd1;
	assign pos_inc  = {1'b0, pos_q} + 17'd1;
	assign sum_b    = sum_q + rx_byte;
	assign to_nack  = (phase_q != PH_EXT);

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		len_n     = len_q;
		lhh_n     = lhh_q;
		flags_n   = flags_q;
		sum_n     = sum_q;
		tick_n    = tick_q;
		res_valid = 1'b0;
		res       = '0;

		if (op == OP_START) begin
			len_n   = '0;
			lhh_n   = '0;
			sum_n   = '0;
			phase_n = PH_ACK;
			pos_n   = '0;
			flags_n = '0;
			tick_n  = '0;
		end else if (op == OP_TICK && phase_q != PH_IDLE) begin
			tick_n = tick_inc;
			if (tick_inc >= cfg.timeout_ticks) begin
				res_valid     = 1'b1;
				res.kind      = KIND_END;
				res.status    = ST_TIMEOUT;
				res.send_nack = to_nack;
			end
		end else if (op == OP_BYTE && phase_q != PH_IDLE) begin
			if (tick_q >= cfg.timeout_ticks) begin
				res_valid     = 1'b1;
				res.kind      = KIND_END;
				res.status    = ST_TIMEOUT;
				res.send_nack = to_nack;
			end else begin
				case (phase_q)
					PH_ACK: begin
						if (rx_byte != ack_byte(pos_q[2:0]))
							flags_n[0] = 1'b1;
						pos_n = pos_inc[15:0];
						if (pos_inc >= 17'd6) begin
							if (flags_n[0]) begin
								res_valid     = 1'b1;
								res.kind      = KIND_END;
								res.status    = ST_BAD_ACK;
								res.send_nack = 1'b1;
							end else begin
								phase_n = PH_HEAD;
								pos_n   = '0;
								flags_n = '0;
								tick_n  = '0;
							end
						end
					end
					PH_HEAD: begin
						if (pos_q < 16'd3) begin
							if (rx_byte != pre_byte(pos_q[1:0]))
								flags_n[0] = 1'b1;
							pos_n = pos_inc[15:0];
						end else if (pos_q == 16'd3) begin
							lhh_n = rx_byte;
							pos_n = pos_inc[15:0];
						end else if (flags_q[0]) begin
							res_valid  = 1'b1;
							res.kind   = KIND_END;
							res.status = ST_BAD_PRE;
						end else if (lhh_q == BYTE_FF && rx_byte == BYTE_FF) begin
							phase_n = PH_EXT;
							pos_n   = '0;
							flags_n = '0;
							tick_n  = '0;
						end else if (lhh_q + rx_byte != BYTE_00) begin
							res_valid  = 1'b1;
							res.kind   = KIND_END;
							res.status = ST_BAD_LCS;
						end else begin
							len_n = {8'd0, lhh_q};
							if (len_n > cfg.max_length) begin
								res_valid  = 1'b1;
								res.kind   = KIND_END;
								res.status = ST_TOO_LONG;
							end else begin
								sum_n   = '0;
								phase_n = (lhh_q == BYTE_00) ? PH_TAIL : PH_DATA;
								pos_n   = '0;
								flags_n = '0;
								tick_n  = '0;
							end
						end
					end
					PH_EXT: begin
						if (pos_q == 16'd0) begin
							lhh_n = rx_byte;
							sum_n = rx_byte;
							pos_n = pos_inc[15:0];
						end else if (pos_q == 16'd1) begin
							len_n = {lhh_q, rx_byte};
							sum_n = sum_b;
							pos_n = pos_inc[15:0];
						end else if (sum_b != BYTE_00) begin
							res_valid  = 1'b1;
							res.kind   = KIND_END;
							res.status = ST_BAD_LCS;
						end else if (len_q > cfg.max_length) begin
							res_valid  = 1'b1;
							res.kind   = KIND_END;
							res.status = ST_TOO_LONG;
						end else begin
							sum_n   = '0;
							phase_n = (len_q == 16'd0) ? PH_TAIL : PH_DATA;
							pos_n   = '0;
							flags_n = '0;
							tick_n  = '0;
						end
					end
					PH_DATA: begin
						sum_n            = sum_b;
						pos_n            = pos_inc[15:0];
						res_valid        = 1'b1;
						res.kind         = KIND_PAYLOAD;
						res.payload_byte = rx_byte;
						if (pos_inc >= {1'b0, len_q}) begin
							phase_n = PH_TAIL;
							pos_n   = '0;
							flags_n = '0;
							tick_n  = '0;
						end
					end
					PH_TAIL: begin
						if (pos_q == 16'd0) begin
							if (sum_b != BYTE_00)
								flags_n[1] = 1'b1;
							pos_n = pos_inc[15:0];
						end else if (flags_q[1] || rx_byte != BYTE_00) begin
							res_valid     = 1'b1;
							res.kind      = KIND_END;
							res.status    = ST_BAD_TAIL;
							res.send_nack = 1'b1;
						end else begin
							res_valid        = 1'b1;
							res.kind         = KIND_END;
							res.status       = ST_OK;
							res.frame_length = len_q;
						end
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
		end

		// end of exchange returns to idle
		if (res_valid && res.kind == KIND_END) begin
			phase_n = PH_IDLE;
			pos_n   = '0;
			flags_n = '0;
			tick_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			len_q   <= '0;
			lhh_q   <= '0;
			flags_q <= '0;
			sum_q   <= '0;
			tick_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			len_q   <= len_n;
			lhh_q   <= lhh_n;
			flags_q <= flags_n;
			sum_q   <= sum_n;
			tick_q  <= tick_n;
		end
	end

endmodule

/* hdl/rrfp_out_reg.sv */
// Result register: holds one result beat and frees the input side as it drains.
module rrfp_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  rrfp_pkg::res_t res,
	output logic           can_take,
	rrfp_out_if.source     out
);
	import rrfp_pkg::*;

	logic valid_q;
	res_t res_q;

	assign can_take         = !valid_q || out.ready;
	assign out.valid        = valid_q;
	assign out.kind         = res_q.kind;
	assign out.payload_byte = res_q.payload_byte;
	assign out.status       = res_q.status;
	assign out.send_nack    = res_q.send_nack;
	assign out.frame_length = res_q.frame_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

endmodule
